@@ rtl/core/ctt_pkg.sv @@
// Shared definitions for the configuration-text tokenizer.
// Token kind codes, the result record type and the character constants.
// No dependencies.
package ctt_pkg;

  localparam int unsigned KindW = 4;
  localparam int unsigned ByteW = 8;

  localparam logic [KindW-1:0] KIND_NEWLINE  = 4'd0;
  localparam logic [KindW-1:0] KIND_EQUAL    = 4'd1;
  localparam logic [KindW-1:0] KIND_COMMA    = 4'd2;
  localparam logic [KindW-1:0] KIND_DOT      = 4'd3;
  localparam logic [KindW-1:0] KIND_LBRACKET = 4'd4;
  localparam logic [KindW-1:0] KIND_RBRACKET = 4'd5;
  localparam logic [KindW-1:0] KIND_LBRACE   = 4'd6;
  localparam logic [KindW-1:0] KIND_RBRACE   = 4'd7;
  localparam logic [KindW-1:0] KIND_CHAR     = 4'd8;
  localparam logic [KindW-1:0] KIND_STR_END  = 4'd9;

  localparam logic [ByteW-1:0] CH_TAB      = 8'h09;
  localparam logic [ByteW-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR       = 8'h0D;
  localparam logic [ByteW-1:0] CH_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] CH_DQUOTE   = 8'h22;
  localparam logic [ByteW-1:0] CH_COMMA    = 8'h2C;
  localparam logic [ByteW-1:0] CH_DOT      = 8'h2E;
  localparam logic [ByteW-1:0] CH_EQUAL    = 8'h3D;
  localparam logic [ByteW-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [ByteW-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [ByteW-1:0] CH_LBRACE   = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE   = 8'h7D;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] ch;
    logic             last;
  } ctt_result_t;

endpackage

@@ rtl/core/config_text_tokenizer_core.sv @@
// Configuration-text tokenizer, top level.
// Input register, single-pass decoder and a two-entry result queue.
// Depends on ctt_pkg.
//
// Usage
//   Input channel (in_valid/in_ready): one text byte per transfer, or an
//   end-of-input mark (in_end_mark high, in_byte_in ignored).
//   Result channel (out_valid/out_ready): one token per transfer. A byte may
//   give no token (blank while idle), one, or two (word ended by a non-blank
//   delimiter, closing quote). out_last_of_run marks the final token of a byte.
// Path: a transferred byte is loaded into the input register, then decoded
//   into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while out_ready stays high and every byte
//   gives at most one token; a byte giving two tokens waits in the input
//   register until the queue can take both; the output drains one token a cycle.
// Stalls: with out_ready low the two-entry queue fills, then the decoded
//   byte waits in the input register and in_ready drops. Nothing is lost.
// Reset (rst_n low, synchronous): mode returns to idle, input register and
//   queue are emptied. No setup is needed afterwards.
module config_text_tokenizer_core
  import ctt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte_in,
  input  logic             in_end_mark,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KindW-1:0] out_token_kind,
  output logic [ByteW-1:0] out_char_out,
  output logic             out_last_of_run
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_QUOTED = 2'd2
  } mode_t;

  mode_t            mode_r, mode_nxt;

  // input register
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_end_r;

  // result queue, entry 0 is the head
  ctt_result_t      q_r [2];
  ctt_result_t      q_nxt [2];
  logic [1:0]       cnt_r, cnt_nxt;

  // --- idle-mode decode of the held byte ---
  logic             is_blank;
  logic             ends_word;
  logic             idle_emit;
  ctt_result_t      idle_res;
  mode_t            idle_mode;

  assign is_blank  = (s1_byte_r == CH_SPACE) || (s1_byte_r == CH_TAB) ||
                     (s1_byte_r == CH_CR);
  assign ends_word = is_blank || (s1_byte_r == CH_NEWLINE) ||
                     (s1_byte_r == CH_COMMA) || (s1_byte_r == CH_DOT) ||
                     (s1_byte_r == CH_LBRACKET) || (s1_byte_r == CH_RBRACKET) ||
                     (s1_byte_r == CH_LBRACE) || (s1_byte_r == CH_RBRACE);

  always_comb begin
    idle_emit = 1'b1;
    idle_mode = MODE_IDLE;
    idle_res  = '{kind: KIND_CHAR, ch: '0, last: 1'b0};
    case (s1_byte_r)
      CH_TAB, CH_CR, CH_SPACE: idle_emit = 1'b0;
      CH_NEWLINE:  idle_res.kind = KIND_NEWLINE;
      CH_EQUAL:    idle_res.kind = KIND_EQUAL;
      CH_COMMA:    idle_res.kind = KIND_COMMA;
      CH_DOT:      idle_res.kind = KIND_DOT;
      CH_LBRACKET: idle_res.kind = KIND_LBRACKET;
      CH_RBRACKET: idle_res.kind = KIND_RBRACKET;
      CH_LBRACE:   idle_res.kind = KIND_LBRACE;
      CH_RBRACE:   idle_res.kind = KIND_RBRACE;
      CH_DQUOTE: begin
        idle_res.ch = s1_byte_r;
        idle_mode   = MODE_QUOTED;
      end
      default: begin
        // anything else opens a bare word, NUL and high bytes included
        idle_res.ch = s1_byte_r;
        idle_mode   = MODE_WORD;
      end
    endcase
  end

  // --- full decode: up to two tokens per byte ---
  logic [1:0]       n_res;
  ctt_result_t      r0, r1;

  always_comb begin
    mode_nxt = mode_r;
    n_res    = 2'd0;
    r0       = '{kind: KIND_STR_END, ch: '0, last: 1'b0};
    r1       = '{kind: KIND_STR_END, ch: '0, last: 1'b0};
    if (s1_end_r) begin
      // end of input closes any open string
      if (mode_r == MODE_WORD || mode_r == MODE_QUOTED) begin
        n_res = 2'd1;
      end
      mode_nxt = MODE_IDLE;
    end else begin
      case (mode_r)
        MODE_WORD: begin
          if (ends_word) begin
            // word closes, delimiter is then treated as in idle
            r1       = idle_res;
            n_res    = idle_emit ? 2'd2 : 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            r0    = '{kind: KIND_CHAR, ch: s1_byte_r, last: 1'b0};
            n_res = 2'd1;
          end
        end
        MODE_QUOTED: begin
          r0    = '{kind: KIND_CHAR, ch: s1_byte_r, last: 1'b0};
          n_res = 2'd1;
          if (s1_byte_r == CH_DQUOTE) begin
            n_res    = 2'd2;
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          // idle, and the unused mode code behaves as idle
          r0       = idle_res;
          n_res    = idle_emit ? 2'd1 : 2'd0;
          mode_nxt = idle_mode;
        end
      endcase
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // --- queue bookkeeping ---
  logic       pop;
  logic [1:0] cnt_after_pop;
  logic       room;
  logic       consume;

  assign pop           = (cnt_r != 2'd0) && out_ready;
  assign cnt_after_pop = cnt_r - {1'b0, pop};
  assign room          = ((2'd2 - cnt_after_pop) >= n_res);
  assign consume       = s1_valid_r && room;
  assign in_ready      = !s1_valid_r || consume;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = cnt_after_pop;
    if (consume && n_res != 2'd0) begin
      q_nxt[cnt_after_pop[0]] = r0;
      if (n_res == 2'd2) begin
        q_nxt[1] = r1;    // two tokens only fit an empty queue
      end
      cnt_nxt = cnt_after_pop + n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      s1_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      if (consume) begin
        mode_r <= mode_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      cnt_r <= cnt_nxt;
    end
    // payload, no reset needed
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
      s1_end_r  <= in_end_mark;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_token_kind  = q_r[0].kind;
  assign out_char_out    = q_r[0].ch;
  assign out_last_of_run = q_r[0].last;

endmodule

@@ rtl/core/ctt_checker.sv @@
// Port-level checks for the configuration-text tokenizer.
// Bound to config_text_tokenizer_core; depends on ctt_pkg.
module ctt_checker
  import ctt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KindW-1:0] out_token_kind,
  input logic [ByteW-1:0] out_char_out,
  input logic             out_last_of_run
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
                                $stable(out_char_out) && $stable(out_last_of_run))
    else $error("stalled token changed");

  // character byte only travels with a string character
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_CHAR |-> out_char_out == '0)
    else $error("non-zero char on non-character token");

  // symbol tokens never have a follower from the same byte
  a_symbol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind < KIND_CHAR |-> out_last_of_run)
    else $error("symbol token not last of its byte");

  // only a string end or a symbol can follow a non-final token of the same byte
  a_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && (out_token_kind == KIND_STR_END || out_token_kind < KIND_CHAR))
    else $error("second token of a byte missing or wrong kind");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_char_out    (out_char_out),
  .out_last_of_run (out_last_of_run)
);

@@ tb/sv/ctt_token_checker.sv @@
// Token checker for config_text_tokenizer_core: predicts tokens per input transfer
// and compares every result transfer against the oldest prediction.
// Depends on ctt_pkg.
module ctt_token_checker
  import ctt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [ByteW-1:0] in_byte_in,
  input  logic             in_end_mark,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [KindW-1:0] out_token_kind,
  input  logic [ByteW-1:0] out_char_out,
  input  logic             out_last_of_run,
  output int unsigned      error_count,
  output int unsigned      tokens_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LEX_IDLE   = 2'd0,
    LEX_WORD   = 2'd1,
    LEX_QUOTED = 2'd2
  } lex_mode_e;

  lex_mode_e   lex_mode;
  ctt_result_t awaited_tokens[$];
  int unsigned tokens_seen;

  function automatic void queue_token(input logic [KindW-1:0] kind,
                                      input logic [ByteW-1:0] ch);
    ctt_result_t t;
    t.kind = kind;
    t.ch   = (kind == KIND_CHAR) ? ch : '0;
    t.last = 1'b0;
    awaited_tokens.push_back(t);
  endfunction

  function automatic bit ends_word(input logic [ByteW-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NEWLINE ||
           b == CH_COMMA || b == CH_DOT || b == CH_LBRACKET || b == CH_RBRACKET ||
           b == CH_LBRACE || b == CH_RBRACE;
  endfunction

  function automatic void lex_idle_byte(input logic [ByteW-1:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_NEWLINE:  queue_token(KIND_NEWLINE, '0);
      CH_EQUAL:    queue_token(KIND_EQUAL, '0);
      CH_COMMA:    queue_token(KIND_COMMA, '0);
      CH_DOT:      queue_token(KIND_DOT, '0);
      CH_LBRACKET: queue_token(KIND_LBRACKET, '0);
      CH_RBRACKET: queue_token(KIND_RBRACKET, '0);
      CH_LBRACE:   queue_token(KIND_LBRACE, '0);
      CH_RBRACE:   queue_token(KIND_RBRACE, '0);
      CH_DQUOTE: begin
        queue_token(KIND_CHAR, b);
        lex_mode = LEX_QUOTED;
      end
      default: begin
        queue_token(KIND_CHAR, b);
        lex_mode = LEX_WORD;
      end
    endcase
  endfunction

  // One accepted input: append its tokens and flag the final one.
  function automatic void lex_input(input logic [ByteW-1:0] b, input logic end_mark);
    int unsigned n_prior;
    ctt_result_t tail;
    n_prior = awaited_tokens.size();
    if (end_mark) begin
      if (lex_mode == LEX_WORD || lex_mode == LEX_QUOTED)
        queue_token(KIND_STR_END, '0);
      lex_mode = LEX_IDLE;
    end else begin
      case (lex_mode)
        LEX_WORD: begin
          if (ends_word(b)) begin
            queue_token(KIND_STR_END, '0);
            lex_mode = LEX_IDLE;
            lex_idle_byte(b);
          end else begin
            queue_token(KIND_CHAR, b);
          end
        end
        LEX_QUOTED: begin
          queue_token(KIND_CHAR, b);
          if (b == CH_DQUOTE) begin
            queue_token(KIND_STR_END, '0);
            lex_mode = LEX_IDLE;
          end
        end
        default: begin
          lex_mode = LEX_IDLE;
          lex_idle_byte(b);
        end
      endcase
    end
    if (awaited_tokens.size() > n_prior) begin
      tail = awaited_tokens.pop_back();
      tail.last = 1'b1;
      awaited_tokens.push_back(tail);
    end
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= 10)
      $display("%0t ns: %s", $time, msg);
  endfunction

  // Results are checked before the same edge's input is predicted: a token can
  // never leave in the cycle its byte is taken.
  always @(posedge clk) begin
    ctt_result_t want;
    if (!rst_n) begin
      lex_mode = LEX_IDLE;
      awaited_tokens.delete();
      error_count = 0;
      tokens_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_tokens.size() == 0) begin
          note_failure($sformatf("token %0d unexpected: kind %0d ch %02h last %0b",
                                 tokens_seen, out_token_kind, out_char_out,
                                 out_last_of_run));
        end else begin
          want = awaited_tokens.pop_front();
          if (out_token_kind !== want.kind || out_char_out !== want.ch ||
              out_last_of_run !== want.last)
            note_failure($sformatf(
              "token %0d mismatch: want kind %0d ch %02h last %0b, got %0d %02h %0b",
              tokens_seen, want.kind, want.ch, want.last,
              out_token_kind, out_char_out, out_last_of_run));
        end
        tokens_seen++;
      end
      if (in_valid && in_ready)
        lex_input(in_byte_in, in_end_mark);
    end
    tokens_awaited = awaited_tokens.size();
  end

endmodule

@@ tb/sv/tb_config_text_tokenizer_core.sv @@
// Top of the config_text_tokenizer_core bench: clock, reset, byte stimulus and
// result-side back-pressure; verdict from the failure count of ctt_token_checker.
// Depends on ctt_pkg, config_text_tokenizer_core and ctt_token_checker.
module tb_config_text_tokenizer_core;
  import ctt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget  = 1500;
  localparam int unsigned QuietItems  = 250;  // tail of the run with no idling
  localparam int unsigned StallLimit  = 400;  // cycles with no transfer at all
  localparam int unsigned DrainCycles = 20;   // padding after the queue has drained

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_byte_in      = '0;
  logic             in_end_mark     = 1'b0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [KindW-1:0] out_token_kind;
  logic [ByteW-1:0] out_char_out;
  logic             out_last_of_run;

  int unsigned error_count;
  int unsigned tokens_awaited;

  // Stimulus bookkeeping, shared by the sender and the result-side process.
  bit          quiet     = 1'b0;  // set for the last stretch: no gaps, no stalls
  bit          gaps_on   = 1'b1;  // sender gaps allowed in this sequence
  bit          in_fire_q = 1'b0;  // input transfer at the last rising edge
  int unsigned n_items   = 0;
  int unsigned stall_cycles = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_calm = 0;

  config_text_tokenizer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_in      (in_byte_in),
    .in_end_mark     (in_end_mark),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

  ctt_token_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_in      (in_byte_in),
    .in_end_mark     (in_end_mark),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run),
    .error_count     (error_count),
    .tokens_awaited  (tokens_awaited)
  );

  // 4 ns clock: low half, then high half.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Registered view of the input handshake, so the sender (which works on the
  // falling edge) learns of a transfer without racing the rising edge.
  always @(posedge clk) begin
    in_fire_q <= in_valid && in_ready;
  end

  // Watchdog: any transfer on either channel restarts the count. The limit is
  // many times the longest sender gap or result-side stall, the worst correct
  // quiet spell.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("[config_text_tokenizer_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result-side back-pressure: random stall bursts, broken up by
  // calm stretches where ready stays high so the queue runs at full rate.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (quiet || sink_calm > 0) begin
      if (sink_calm > 0)
        sink_calm <= sink_calm - 1;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      sink_calm <= $urandom_range(40, 150);
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic bit is_blank(input logic [ByteW-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR;
  endfunction

  // Bytes that end a bare word or stand as punctuation on their own.
  function automatic bit is_delim(input logic [ByteW-1:0] b);
    return is_blank(b) || b == CH_NEWLINE || b == CH_COMMA || b == CH_DOT ||
           b == CH_LBRACKET || b == CH_RBRACKET || b == CH_LBRACE || b == CH_RBRACE;
  endfunction

  // A byte that opens a bare word: mostly identifier characters, sometimes any
  // byte that is not a blank, punctuation or a quote.
  function automatic logic [ByteW-1:0] word_start_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 3))
      0:       b = 8'h61 + ByteW'($urandom_range(0, 25));   // a..z
      1:       b = 8'h30 + ByteW'($urandom_range(0, 9));    // 0..9
      2:       b = 8'h41 + ByteW'($urandom_range(0, 25));   // A..Z
      default: begin
        do b = ByteW'($urandom_range(0, 255));
        while (is_delim(b) || b == CH_EQUAL || b == CH_DQUOTE);
      end
    endcase
    return b;
  endfunction

  // Inside a word, '=' and '"' are plain characters, so mix them in now and then.
  function automatic logic [ByteW-1:0] word_body_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 15))
      0:       b = CH_EQUAL;
      1:       b = CH_DQUOTE;
      default: b = word_start_byte();
    endcase
    return b;
  endfunction

  // Offer one item and hold it until the transfer. Every transfer counts.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic end_mark);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_byte_in  = b;
    in_end_mark = end_mark;
    @(negedge clk);
    while (!in_fire_q) @(negedge clk);
    n_items++;
  endtask

  // Hold the input off until every predicted token has been transferred.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (tokens_awaited != 0) @(negedge clk);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       send_byte(CH_TAB, 1'b0);
        1:       send_byte(CH_CR, 1'b0);
        default: send_byte(CH_SPACE, 1'b0);
      endcase
    end
  endtask

  task automatic send_word();
    send_byte(word_start_byte(), 1'b0);
    repeat ($urandom_range(0, 6)) send_byte(word_body_byte(), 1'b0);
  endtask

  // Quoted string with any content but a quote; now and then the closing quote is missing
  // and whatever follows lands inside the string.
  task automatic send_quoted();
    logic [ByteW-1:0] b;
    send_byte(CH_DQUOTE, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      do b = ByteW'($urandom_range(0, 255));
      while (b == CH_DQUOTE);
      send_byte(b, 1'b0);
    end
    if ($urandom_range(0, 9) != 0)
      send_byte(CH_DQUOTE, 1'b0);
  endtask

  task automatic send_scalar();
    if ($urandom_range(0, 1) == 0) send_quoted();
    else                           send_word();
  endtask

  // Value: scalar, list of scalars, or inline table of key = scalar pairs.
  task automatic send_value();
    int unsigned n;
    case ($urandom_range(0, 5))
      0: begin
        n = $urandom_range(0, 3);
        send_byte(CH_LBRACKET, 1'b0);
        for (int unsigned i = 0; i < n; i++) begin
          send_blanks();
          send_scalar();
          if (i + 1 < n) send_byte(CH_COMMA, 1'b0);
        end
        send_blanks();
        send_byte(CH_RBRACKET, 1'b0);
      end
      1: begin
        n = $urandom_range(0, 2);
        send_byte(CH_LBRACE, 1'b0);
        for (int unsigned i = 0; i < n; i++) begin
          send_blanks();
          send_word();
          send_byte(CH_SPACE, 1'b0);
          send_byte(CH_EQUAL, 1'b0);
          send_blanks();
          send_scalar();
          if (i + 1 < n) send_byte(CH_COMMA, 1'b0);
        end
        send_byte(CH_RBRACE, 1'b0);
      end
      default: send_scalar();
    endcase
  endtask

  // One line of the format: a section header or a (dotted) key = value pair.
  task automatic send_line();
    send_blanks();
    if ($urandom_range(0, 5) == 0) begin
      send_byte(CH_LBRACKET, 1'b0);
      send_word();
      send_byte(CH_RBRACKET, 1'b0);
    end else begin
      send_word();
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_DOT, 1'b0);
        send_word();
      end
      send_blanks();
      // A word runs on through '=', so a key needs a blank before the '='.
      if ($urandom_range(0, 7) != 0) send_byte(CH_SPACE, 1'b0);
      send_byte(CH_EQUAL, 1'b0);
      send_blanks();
      send_value();
    end
    send_blanks();
    if ($urandom_range(0, 3) == 0) send_byte(CH_CR, 1'b0);
    send_byte(CH_NEWLINE, 1'b0);
  endtask

  initial begin
    bit paused;
    int unsigned pick;
    paused = 1'b0;

    // Synchronous reset, held from the start and released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle blanks give nothing, each punctuation byte, end mark
    // while idle, a word starting with NUL and holding 0xFF, '=' and '"' inside a
    // word, a word closed by punctuation (two tokens from one byte), a quoted
    // string holding a blank and a high byte, the closing quote (character
    // plus end), words closed by a blank and by the end mark, and an open
    // string closed by the end mark.
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_NEWLINE, 1'b0);
    send_byte(CH_EQUAL, 1'b0);
    send_byte(CH_COMMA, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_LBRACKET, 1'b0);
    send_byte(CH_RBRACKET, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_EQUAL, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(8'h6B, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // Random part: mostly well-formed lines, mixed with raw noise, bare values and
    // stray end marks. Idling stops for the last stretch.
    while (n_items < ItemTarget) begin
      quiet   = (n_items + QuietItems >= ItemTarget);
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 19);
      if (pick < 13) begin
        send_line();
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 19) begin
        send_value();
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)), 1'b1);
      end
      // Once mid-run, let the result queue empty before carrying on.
      if (!paused && n_items >= ItemTarget / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0 && tokens_awaited == 0) begin
      $display("[config_text_tokenizer_core] OK");
    end else begin
      $display("[config_text_tokenizer_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ctt_pkg.sv
rtl/core/config_text_tokenizer_core.sv
rtl/core/ctt_checker.sv
tb/sv/ctt_token_checker.sv
tb/sv/tb_config_text_tokenizer_core.sv
